// ===== hw/rtl/charge_time_to_target_estimator_core_macros.svh =====
// assertion helpers for the charge time estimator
`ifndef CHARGE_TIME_TO_TARGET_ESTIMATOR_CORE_MACROS_SVH
`define CHARGE_TIME_TO_TARGET_ESTIMATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CTTE_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CTTE_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/ctte_pkg.sv =====
package ctte_pkg;

  localparam int PERCENT_FRAC_BITS_DEF = 16;
  localparam int NUM_BANDS = 12;
  localparam int BAND_W = 4;
  localparam int DELAY_W = 43;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  // 2.5e9 = 9765625 * 2^8
  localparam int K_W = 24;
  localparam logic [K_W-1:0] TIME_K = 24'd9765625;
  localparam int TIME_SHIFT = 8;
  localparam logic [K_W-1:0] LCM_DIV = 24'd153153;
  localparam logic [K_W-1:0] PCT_SCALE = 24'd100;

  // quotient-side numerator width of the final division, independent of frac bits
  localparam int NUM_W = 59;
  // divisor width: 153153 * charge_rate
  localparam int DIV_W = 35;

  localparam int FULL_W = 16;
  localparam int TGT_W = 7;
  localparam int RATE_W = 17;
  localparam int REM_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [TGT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [FULL_W-1:0] FULL_RESET = 16'd2200;
  localparam logic [TGT_W-1:0] TGT_RESET = 7'd90;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_CAPACITY  = 2'd0,
    CFG_TARGET_PERCENT = 2'd1,
    CFG_CHARGE_RATE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_REM,
    S_LOAD_P,
    S_DIV_P,
    S_CHECK,
    S_BAND_MUL,
    S_BAND_ACC,
    S_RATE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ACC,
    S_LOAD_D,
    S_DIV_D,
    S_FIN
  } state_e;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // band edges in whole percent
  function automatic logic [TGT_W-1:0] band_edge(input logic [BAND_W-1:0] idx);
    logic [TGT_W-1:0] e;
    case (idx)
      4'd0:    e = 7'd0;
      4'd1:    e = 7'd71;
      4'd2:    e = 7'd76;
      4'd3:    e = 7'd84;
      4'd4:    e = 7'd85;
      4'd5:    e = 7'd86;
      4'd6:    e = 7'd87;
      4'd7:    e = 7'd90;
      4'd8:    e = 7'd93;
      4'd9:    e = 7'd96;
      4'd10:   e = 7'd98;
      4'd11:   e = 7'd99;
      default: e = 7'd100;
    endcase
    return e;
  endfunction

  // lcm of the factors divided by each band's factor
  function automatic logic [K_W-1:0] band_weight(input logic [BAND_W-1:0] idx);
    logic [K_W-1:0] w;
    case (idx)
      4'd0:    w = 24'd612612;
      4'd1:    w = 24'd680680;
      4'd2:    w = 24'd720720;
      4'd3:    w = 24'd765765;
      4'd4:    w = 24'd816816;
      4'd5:    w = 24'd875160;
      4'd6:    w = 24'd942480;
      4'd7:    w = 24'd1113840;
      4'd8:    w = 24'd1225224;
      4'd9:    w = 24'd1531530;
      4'd10:   w = 24'd2042040;
      4'd11:   w = 24'd3063060;
      default: w = 24'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/charge_time_to_target_estimator_core.sv =====
// charge time to target estimator
//
// command channel: remaining_capacity_i is taken at a rising edge with start high
// and busy low; busy then stays high until the result is out. one result per
// transaction: done_o is high for exactly one cycle with delay_us_o and
// already_reached_o valid; the receiver cannot hold it off, so nothing stalls.
// configuration: cfg_valid_i/cfg_ready_o channel with cfg_index_i and cfg_data_i;
// ready is always high, write only while busy is low. index 0 full capacity,
// 1 target percent, 2 charge rate; index 3 is ignored.
// F = PERCENT_FRAC_BITS, percent quotient width PW = F + 23. a target already
// reached skips the band walk, and a zero charge rate skips the final division.
// the cost is set by the shared restoring divider, one quotient bit a cycle,
// used for the percent (PW steps) and the final time (59 steps), plus one
// shared multiplier that walks the twelve bands, a multiply state and an
// accumulate state per band.
// a new start is taken only once the last result is out, at the earliest in
// the cycle done_o is high.
// reset: registers return to 2200 mAh, 90 percent, rate 1; sequencer idles.
module charge_time_to_target_estimator_core #(
  parameter int PERCENT_FRAC_BITS = ctte_pkg::PERCENT_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [ctte_pkg::REM_W-1:0]       remaining_capacity_i,
  // result strobe
  output logic                             done_o,
  output logic [ctte_pkg::DELAY_W-1:0]     delay_us_o,
  output logic                             already_reached_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ctte_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ctte_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ctte_pkg::*;

  `include "charge_time_to_target_estimator_core_macros.svh"

  localparam int F    = PERCENT_FRAC_BITS;
  localparam int PW   = F + 23;            // percent quotient, rem * 100 < 2^23
  localparam int SPW  = F + 7;             // one band span
  localparam int SW   = F + 27;            // weighted span sum
  localparam int HALF = (SW + 1) / 2;      // split of the sum for the time product
  localparam int NW   = SW + K_W;          // sum times time constant
  localparam int MA   = max_int(max_int(SPW, HALF), RATE_W + 1);
  localparam int PRW  = MA + K_W;
  localparam int QW   = max_int(PW, DELAY_W);
  localparam int RW   = DIV_W + 1;
  localparam int CW   = $clog2(NUM_W);

  // configuration registers
  logic [FULL_W-1:0] full_cap_q;
  logic [TGT_W-1:0]  target_q;
  logic [RATE_W-1:0] rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_cap_q <= FULL_RESET;
      target_q   <= TGT_RESET;
      rate_q     <= RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FULL_CAPACITY:  full_cap_q <= cfg_data_i[FULL_W-1:0];
        CFG_TARGET_PERCENT: target_q   <= cfg_data_i[TGT_W-1:0];
        CFG_CHARGE_RATE:    rate_q     <= cfg_data_i[RATE_W-1:0];
        default:            ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_e            state_q, state_d;
  logic              done_q, done_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [PRW-1:0]    prod_q, prod_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [DIV_W-1:0]  r_q, r_d;
  logic [QW-1:0]     q_q, q_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              sat_q, sat_d;
  logic              flag_q, flag_d;
  logic [BAND_W-1:0] band_q, band_d;
  logic [SW-1:0]     sum_q, sum_d;
  logic [NW-1:0]     acc_q, acc_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic              reached_q, reached_d;

  // shared divider step, one quotient bit per cycle
  logic [RW-1:0] r_shift, r_sub;
  logic          div_ge;
  logic [DIV_W-1:0] r_next;
  logic [QW-1:0] q_next;

  assign r_shift = {r_q, num_q[cnt_q]};
  assign r_sub   = r_shift - {1'b0, div_q};
  assign div_ge  = (r_shift >= {1'b0, div_q});
  assign r_next  = div_ge ? r_sub[DIV_W-1:0] : r_shift[DIV_W-1:0];
  assign q_next  = {q_q[QW-2:0], div_ge};

  // shared multiplier
  logic [MA-1:0]  mul_a;
  logic [K_W-1:0] mul_b;
  logic [PRW-1:0] mul_p;

  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  // band span: part of [p, target] inside the current band
  logic [PW-1:0]    pct;
  logic [PW-1:0]    e_lo, e_hi, t_cap, t_full, top, base;
  logic [TGT_W-1:0] tcap_pct;
  logic [PW-1:0]    span_w;
  logic [SPW-1:0]   span;

  assign pct      = q_q[PW-1:0];
  assign tcap_pct = (target_q > PCT_FULL) ? PCT_FULL : target_q;
  assign t_cap    = PW'(tcap_pct) << F;
  assign t_full   = PW'(target_q) << F;
  assign e_lo     = PW'(band_edge(band_q)) << F;
  assign e_hi     = PW'(band_edge(band_q + BAND_W'(1))) << F;
  assign top      = (e_hi < t_cap) ? e_hi : t_cap;
  assign base     = (pct < e_lo) ? e_lo : ((pct < top) ? pct : top);
  assign span_w   = (e_lo >= t_cap) ? '0 : (top - base);
  assign span     = span_w[SPW-1:0];

  logic [NW-1:0] acc_shr;
  assign acc_shr = acc_q >> (F - TIME_SHIFT);

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    rem_d     = rem_q;
    prod_d    = prod_q;
    num_d     = num_q;
    div_d     = div_q;
    r_d       = r_q;
    q_d       = q_q;
    cnt_d     = cnt_q;
    sat_d     = sat_q;
    flag_d    = flag_q;
    band_d    = band_q;
    sum_d     = sum_q;
    acc_d     = acc_q;
    delay_d   = delay_q;
    reached_d = reached_q;
    mul_a     = MA'(rem_q);
    mul_b     = PCT_SCALE;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          rem_d   = remaining_capacity_i;
          state_d = S_MUL_REM;
        end
      end
      S_MUL_REM: begin
        mul_a   = MA'(rem_q);
        mul_b   = PCT_SCALE;
        prod_d  = mul_p;
        state_d = S_LOAD_P;
      end
      S_LOAD_P: begin
        // percent = rem * 100 * 2^F / full, zero full acts as one
        num_d   = NUM_W'(prod_q[REM_W+TGT_W-1:0]) << F;
        div_d   = (full_cap_q == '0) ? DIV_W'(1) : DIV_W'(full_cap_q);
        r_d     = '0;
        q_d     = '0;
        cnt_d   = CW'(PW - 1);
        state_d = S_DIV_P;
      end
      S_DIV_P: begin
        r_d   = r_next;
        q_d   = q_next;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        flag_d = (pct >= t_full);
        band_d = '0;
        sum_d  = '0;
        sat_d  = 1'b0;
        if (pct >= t_full) begin
          state_d = S_FIN;
        end else begin
          state_d = S_BAND_MUL;
        end
      end
      S_BAND_MUL: begin
        mul_a   = MA'(span);
        mul_b   = band_weight(band_q);
        prod_d  = mul_p;
        state_d = S_BAND_ACC;
      end
      S_BAND_ACC: begin
        sum_d  = sum_q + SW'(prod_q);
        band_d = band_q + BAND_W'(1);
        if (band_q == BAND_W'(NUM_BANDS - 1)) begin
          state_d = S_RATE;
        end else begin
          state_d = S_BAND_MUL;
        end
      end
      S_RATE: begin
        mul_a  = MA'(rate_q);
        mul_b  = LCM_DIV;
        prod_d = mul_p;
        if (rate_q == '0) begin
          sat_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        div_d   = prod_q[DIV_W-1:0];
        mul_a   = MA'(sum_q[HALF-1:0]);
        mul_b   = TIME_K;
        prod_d  = mul_p;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        acc_d   = NW'(prod_q);
        mul_a   = MA'(sum_q[SW-1:HALF]);
        mul_b   = TIME_K;
        prod_d  = mul_p;
        state_d = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        acc_d   = acc_q + (NW'(prod_q) << HALF);
        state_d = S_LOAD_D;
      end
      S_LOAD_D: begin
        // sum * 2.5e9 / 2^F, then divide by 153153 * rate
        num_d   = acc_shr[NUM_W-1:0];
        r_d     = '0;
        q_d     = '0;
        sat_d   = 1'b0;
        cnt_d   = CW'(NUM_W - 1);
        state_d = S_DIV_D;
      end
      S_DIV_D: begin
        r_d   = r_next;
        q_d   = q_next;
        cnt_d = cnt_q - CW'(1);
        // any quotient bit at or above the output width saturates
        if (div_ge && (cnt_q >= CW'(DELAY_W))) begin
          sat_d = 1'b1;
        end
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d    = 1'b1;
        reached_d = flag_q;
        if (flag_q) begin
          delay_d = '0;
        end else if (sat_q) begin
          delay_d = DELAY_MAX;
        end else begin
          delay_d = q_q[DELAY_W-1:0];
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    prod_q    <= prod_d;
    num_q     <= num_d;
    div_q     <= div_d;
    r_q       <= r_d;
    q_q       <= q_d;
    cnt_q     <= cnt_d;
    sat_q     <= sat_d;
    flag_q    <= flag_d;
    band_q    <= band_d;
    sum_q     <= sum_d;
    acc_q     <= acc_d;
    delay_q   <= delay_d;
    reached_q <= reached_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign delay_us_o        = delay_q;
  assign already_reached_o = reached_q;

  `CTTE_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobe while busy")
  `CTTE_ASSERT_NXT(a_start_busy, start && !busy, busy, "start not taken")
  `CTTE_ASSERT_IMP(a_reached_zero, done_o && already_reached_o, delay_us_o == '0, "reached with delay")
  `CTTE_ASSERT_NXT(a_div_end, (state_q == S_DIV_D) && (cnt_q == '0), state_q == S_FIN, "divider overrun")
  `CTTE_ASSERT_IMP(a_done_from_fin, done_o, $past(state_q == S_FIN), "strobe without finish")

endmodule

// ===== sim/charge_time_to_target_estimator_core_tb.sv =====
module charge_time_to_target_estimator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctte_pkg::*;

  // fixed point and arithmetic constants of the estimate
  localparam int FRAC_BITS = PERCENT_FRAC_BITS_DEF;
  localparam logic [63:0] TIME_NUMERATOR = 64'd2500000000;
  localparam logic [63:0] LCM_PER_RATE = 64'd153153;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int RANDOM_PHASES = 15;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES = 150;

  // band edges in whole percent and lcm / factor per band
  localparam int unsigned BAND_EDGES [0:12] = '{0, 71, 76, 84, 85, 86, 87, 90, 93, 96, 98,
                                                99, 100};
  localparam int unsigned BAND_WEIGHTS [0:11] = '{612612, 680680, 720720, 765765, 816816,
                                                  875160, 942480, 1113840, 1225224, 1531530,
                                                  2042040, 3063060};

  typedef struct packed {
    logic [DELAY_W-1:0] delay_us;
    logic               already_reached;
  } estimate_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [REM_W-1:0]      remaining_capacity_i = '0;
  logic                  done_o;
  logic [DELAY_W-1:0]    delay_us_o;
  logic                  already_reached_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // register copies, updated at each config handshake
  logic [FULL_W-1:0] full_cap_q = FULL_RESET;
  logic [TGT_W-1:0]  target_pct_q = TGT_RESET;
  logic [RATE_W-1:0] rate_q = RATE_RESET;

  logic [REM_W-1:0] pending_caps [$];
  estimate_t        expected_estimates [$];
  estimate_t        oldest_estimate;
  int unsigned      gap_left = 0;
  int unsigned      burst_left = 0;
  int unsigned      accepted_count = 0;
  int unsigned      error_count = 0;
  logic             drain_wait = 1'b0;

  charge_time_to_target_estimator_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .remaining_capacity_i(remaining_capacity_i),
    .done_o              (done_o),
    .delay_us_o          (delay_us_o),
    .already_reached_o   (already_reached_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // time to target for one remaining capacity under the current registers
  function automatic estimate_t predict_estimate(input logic [REM_W-1:0] cap);
    estimate_t    est;
    logic [63:0]  full_div, pct_fx, tgt_fx, walk_top, band_lo, band_hi, top, base;
    logic [127:0] weighted_sum, numer, denom, quot;
    est.delay_us = '0;
    est.already_reached = 1'b0;
    // a zero full capacity divides as one
    full_div = (full_cap_q == '0) ? 64'd1 : 64'(full_cap_q);
    pct_fx = ((64'(cap) * 64'd100) << FRAC_BITS) / full_div;
    tgt_fx = 64'(target_pct_q) << FRAC_BITS;
    // flag uses the register as written, the band walk stops at 100 percent
    walk_top = ((target_pct_q > PCT_FULL) ? 64'(PCT_FULL) : 64'(target_pct_q)) << FRAC_BITS;
    if (pct_fx >= tgt_fx) begin
      est.already_reached = 1'b1;
      return est;
    end
    weighted_sum = '0;
    for (int k = 0; k < NUM_BANDS; k++) begin
      band_lo = 64'(BAND_EDGES[k]) << FRAC_BITS;
      band_hi = 64'(BAND_EDGES[k+1]) << FRAC_BITS;
      if (band_lo < walk_top) begin
        top = (band_hi < walk_top) ? band_hi : walk_top;
        base = (pct_fx < band_lo) ? band_lo : ((pct_fx < top) ? pct_fx : top);
        weighted_sum += 128'(top - base) * 128'(BAND_WEIGHTS[k]);
      end
    end
    if (rate_q == '0) begin
      est.delay_us = DELAY_MAX;
    end else begin
      // one truncation of the exact sum, then saturation
      numer = weighted_sum * 128'(TIME_NUMERATOR);
      denom = (128'(LCM_PER_RATE) * 128'(rate_q)) << FRAC_BITS;
      quot = numer / denom;
      est.delay_us = (quot > 128'(DELAY_MAX)) ? DELAY_MAX : quot[DELAY_W-1:0];
    end
    return est;
  endfunction

  // idle cycles after a transaction: mostly none or short, a few long, some bursts
  function automatic int unsigned next_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) burst_left = $urandom_range(10, 40);
    if (roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 4);
    if (roll < 96) return $urandom_range(5, 140);
    return $urandom_range(141, 400);
  endfunction

  // remaining capacity biased toward band edges and the target boundary
  function automatic logic [REM_W-1:0] pick_capacity();
    int full_eff, edge_pct, cap;
    full_eff = (full_cap_q == '0) ? 1 : int'(full_cap_q);
    case ($urandom_range(9))
      0, 1: cap = int'($urandom_range(65535));
      2, 3, 4: begin
        edge_pct = int'(BAND_EDGES[$urandom_range(12)]);
        cap = full_eff * edge_pct / 100 + int'($urandom_range(4)) - 2;
      end
      5: cap = (full_eff * int'(target_pct_q) + 99) / 100 - int'($urandom_range(1));
      default: cap = int'($urandom_range(full_eff));
    endcase
    if (cap < 0) cap = 0;
    if (cap > 65535) cap = 65535;
    return cap[REM_W-1:0];
  endfunction

  // driver: one transaction per accepted start, start held while busy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      remaining_capacity_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_estimates.push_back(predict_estimate(remaining_capacity_i));
        accepted_count++;
        // now and then hold the sender until every result is back
        if (accepted_count == 40 || $urandom_range(39) == 0) drain_wait = 1'b1;
        gap_left = next_gap();
      end else if (drain_wait && !start && expected_estimates.size() == 0) begin
        drain_wait = 1'b0;
      end
      if (start && busy) begin
        // not taken yet, keep offering the same transaction
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (!drain_wait && pending_caps.size() != 0) begin
        start <= 1'b1;
        remaining_capacity_i <= pending_caps.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed result matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_estimates.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, delay_us %0d already_reached %0b",
                 $realtime, delay_us_o, already_reached_o);
      end else begin
        oldest_estimate = expected_estimates.pop_front();
        if (delay_us_o !== oldest_estimate.delay_us) begin
          error_count++;
          $display("%0t: delay_us mismatch, expected %0d actual %0d", $realtime,
                   oldest_estimate.delay_us, delay_us_o);
        end
        if (already_reached_o !== oldest_estimate.already_reached) begin
          error_count++;
          $display("%0t: already_reached mismatch, expected %0b actual %0b", $realtime,
                   oldest_estimate.already_reached, already_reached_o);
        end
      end
    end
  end

  // register write over the config channel, copy updated at the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FULL_CAPACITY:  full_cap_q = data[FULL_W-1:0];
      CFG_TARGET_PERCENT: target_pct_q = data[TGT_W-1:0];
      CFG_CHARGE_RATE:    rate_q = data[RATE_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // block is idle once nothing is queued, in flight or expected
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_caps.size() != 0 || expected_estimates.size() != 0 || start || busy);
  endtask

  task automatic randomize_config();
    logic [CFG_DATA_W-1:0] data;
    case ($urandom_range(9))
      0: data = '0;
      1: data = 17'd1;
      2: data = 17'd65535;
      3: data = CFG_DATA_W'($urandom_range(131071));
      default: data = CFG_DATA_W'($urandom_range(500, 6000));
    endcase
    write_reg(CFG_FULL_CAPACITY, data);
    case ($urandom_range(9))
      0: data = '0;
      1: data = 17'd100;
      2: data = CFG_DATA_W'($urandom_range(101, 127));
      3: data = CFG_DATA_W'($urandom_range(131071));
      default: data = CFG_DATA_W'($urandom_range(40, 100));
    endcase
    write_reg(CFG_TARGET_PERCENT, data);
    case ($urandom_range(9))
      0: data = '0;
      1: data = 17'd131071;
      2: data = 17'd1;
      3: data = CFG_DATA_W'($urandom_range(131071));
      default: data = CFG_DATA_W'($urandom_range(1, 99999));
    endcase
    write_reg(CFG_CHARGE_RATE, data);
    // writes to the unused index must leave every register alone
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(131071)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: rate 1, exact target boundary, capacity extremes
    pending_caps = '{16'd0, 16'd65535, 16'd1980, 16'd1979, 16'd2200};
    wait_idle();

    // full capacity of 100 puts every band edge on a whole capacity step
    write_reg(CFG_FULL_CAPACITY, 17'd100);
    write_reg(CFG_TARGET_PERCENT, 17'd100);
    write_reg(CFG_CHARGE_RATE, 17'd99999);
    pending_caps = '{16'd0, 16'd70, 16'd71, 16'd76, 16'd84, 16'd85, 16'd86, 16'd87,
                     16'd90, 16'd93, 16'd96, 16'd98, 16'd99, 16'd100};
    wait_idle();

    // zero full capacity, target above 100, widest rate
    write_reg(CFG_FULL_CAPACITY, 17'd0);
    write_reg(CFG_TARGET_PERCENT, 17'd127);
    write_reg(CFG_CHARGE_RATE, 17'd131071);
    pending_caps = '{16'd0, 16'd1, 16'd65535};
    wait_idle();

    // zero target, then zero rate with the target still ahead
    write_reg(CFG_FULL_CAPACITY, 17'd65535);
    write_reg(CFG_TARGET_PERCENT, 17'd0);
    write_reg(CFG_CHARGE_RATE, 17'd0);
    write_reg(CFG_UNUSED_IDX, 17'h1ffff);
    pending_caps = '{16'd0};
    wait_idle();
    write_reg(CFG_TARGET_PERCENT, 17'd50);
    pending_caps = '{16'd65535, 16'd0};
    wait_idle();

    // random phases, each under fresh register settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      randomize_config();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_caps.push_back(pick_capacity());
      wait_idle();
    end

    // let any stray strobe show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** charge_time_to_target_estimator_core: PASSED **");
    end else begin
      $display("** charge_time_to_target_estimator_core: FAILED **");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("** charge_time_to_target_estimator_core: FAILED **");
    $finish;
  end

endmodule
